>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that must also hold during reset
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rvid_pkg.sv
// shared types, opcodes, operation ids and stream layout of the rv32i decoder
package rvid_pkg;

  // major opcodes
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  // exact system words
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  // operation ids in decoder order
  localparam logic [5:0] ID_LB     = 6'd0,  ID_LH     = 6'd1,  ID_LW     = 6'd2;
  localparam logic [5:0] ID_LBU    = 6'd3,  ID_LHU    = 6'd4,  ID_FENCE  = 6'd5;
  localparam logic [5:0] ID_FENCEI = 6'd6,  ID_ADDI   = 6'd7,  ID_SLLI   = 6'd8;
  localparam logic [5:0] ID_SLTI   = 6'd9,  ID_SLTIU  = 6'd10, ID_XORI   = 6'd11;
  localparam logic [5:0] ID_SRLI   = 6'd12, ID_SRAI   = 6'd13, ID_ORI    = 6'd14;
  localparam logic [5:0] ID_ANDI   = 6'd15, ID_AUIPC  = 6'd16, ID_SB     = 6'd17;
  localparam logic [5:0] ID_SH     = 6'd18, ID_SW     = 6'd19, ID_ADD    = 6'd20;
  localparam logic [5:0] ID_SUB    = 6'd21, ID_SLL    = 6'd22, ID_SLT    = 6'd23;
  localparam logic [5:0] ID_SLTU   = 6'd24, ID_XOR    = 6'd25, ID_SRL    = 6'd26;
  localparam logic [5:0] ID_SRA    = 6'd27, ID_OR     = 6'd28, ID_AND    = 6'd29;
  localparam logic [5:0] ID_LUI    = 6'd30, ID_BEQ    = 6'd31, ID_BNE    = 6'd32;
  localparam logic [5:0] ID_BLT    = 6'd33, ID_BGE    = 6'd34, ID_BLTU   = 6'd35;
  localparam logic [5:0] ID_BGEU   = 6'd36, ID_JALR   = 6'd37, ID_JAL    = 6'd38;
  localparam logic [5:0] ID_ECALL  = 6'd39, ID_EBREAK = 6'd40, ID_CSRRW  = 6'd41;
  localparam logic [5:0] ID_CSRRS  = 6'd42, ID_CSRRC  = 6'd43, ID_CSRRWI = 6'd44;
  localparam logic [5:0] ID_CSRRSI = 6'd45, ID_CSRRCI = 6'd46;

  // encoding format
  typedef enum logic [2:0] {
    FMT_R    = 3'd0,
    FMT_I    = 3'd1,
    FMT_S    = 3'd2,
    FMT_B    = 3'd3,
    FMT_U    = 3'd4,
    FMT_J    = 3'd5,
    FMT_NONE = 3'd6
  } fmt_e;

  // opcode class flags and side conditions found in the first stage
  typedef struct packed {
    logic       is_load;
    logic       is_fence;
    logic       is_opimm;
    logic       is_auipc;
    logic       is_store;
    logic       is_op;
    logic       is_lui;
    logic       is_branch;
    logic       is_jalr;
    logic       is_jal;
    logic       is_sys;
    logic [2:0] funct3;
    logic       f7_nz;
    logic       is_ecall;
    logic       is_ebreak;
  } predec_t;

  // classification result handed from the id decoder
  typedef struct packed {
    logic       ok;
    logic [5:0] id;
    fmt_e       fmt;
  } class_t;

  // output stream layout
  localparam int unsigned TDATA_W  = 88;
  localparam int unsigned TUSER_W  = 4;
  localparam int unsigned IN_TDATA_W = 32;

endpackage

>>> rtl/rvid_id_decode.sv
// operation id, format and recognition from the predecoded opcode class
module rvid_id_decode import rvid_pkg::*; (
  input  predec_t pd_i,
  output class_t  cls_o
);

  logic       ok;
  logic [5:0] id;
  fmt_e       fmt;

  // classify by opcode class, then funct3
  always_comb begin
    ok  = 1'b0;
    id  = ID_LB;
    fmt = FMT_NONE;
    if (pd_i.is_load) begin
      fmt = FMT_I;
      unique case (pd_i.funct3)
        3'd0: begin ok = 1'b1; id = ID_LB;  end
        3'd1: begin ok = 1'b1; id = ID_LH;  end
        3'd2: begin ok = 1'b1; id = ID_LW;  end
        3'd4: begin ok = 1'b1; id = ID_LBU; end
        3'd5: begin ok = 1'b1; id = ID_LHU; end
        default: ok = 1'b0;
      endcase
    end else if (pd_i.is_fence) begin
      fmt = FMT_I;
      unique case (pd_i.funct3)
        3'd0: begin ok = 1'b1; id = ID_FENCE;  end
        3'd1: begin ok = 1'b1; id = ID_FENCEI; end
        default: ok = 1'b0;
      endcase
    end else if (pd_i.is_opimm) begin
      fmt = FMT_I;
      ok  = 1'b1;
      unique case (pd_i.funct3)
        3'd0: id = ID_ADDI;
        3'd1: id = ID_SLLI;
        3'd2: id = ID_SLTI;
        3'd3: id = ID_SLTIU;
        3'd4: id = ID_XORI;
        3'd5: id = pd_i.f7_nz ? ID_SRAI : ID_SRLI;
        3'd6: id = ID_ORI;
        default: id = ID_ANDI;
      endcase
    end else if (pd_i.is_auipc) begin
      fmt = FMT_U;
      ok  = 1'b1;
      id  = ID_AUIPC;
    end else if (pd_i.is_store) begin
      fmt = FMT_S;
      unique case (pd_i.funct3)
        3'd0: begin ok = 1'b1; id = ID_SB; end
        3'd1: begin ok = 1'b1; id = ID_SH; end
        3'd2: begin ok = 1'b1; id = ID_SW; end
        default: ok = 1'b0;
      endcase
    end else if (pd_i.is_op) begin
      fmt = FMT_R;
      ok  = 1'b1;
      unique case (pd_i.funct3)
        3'd0: id = pd_i.f7_nz ? ID_SUB : ID_ADD;
        3'd1: id = ID_SLL;
        3'd2: id = ID_SLT;
        3'd3: id = ID_SLTU;
        3'd4: id = ID_XOR;
        3'd5: id = pd_i.f7_nz ? ID_SRA : ID_SRL;
        3'd6: id = ID_OR;
        default: id = ID_AND;
      endcase
    end else if (pd_i.is_lui) begin
      fmt = FMT_U;
      ok  = 1'b1;
      id  = ID_LUI;
    end else if (pd_i.is_branch) begin
      fmt = FMT_B;
      unique case (pd_i.funct3)
        3'd0: begin ok = 1'b1; id = ID_BEQ;  end
        3'd1: begin ok = 1'b1; id = ID_BNE;  end
        3'd4: begin ok = 1'b1; id = ID_BLT;  end
        3'd5: begin ok = 1'b1; id = ID_BGE;  end
        3'd6: begin ok = 1'b1; id = ID_BLTU; end
        3'd7: begin ok = 1'b1; id = ID_BGEU; end
        default: ok = 1'b0;
      endcase
    end else if (pd_i.is_jalr) begin
      fmt = FMT_I;
      ok  = 1'b1;
      id  = ID_JALR;
    end else if (pd_i.is_jal) begin
      fmt = FMT_J;
      ok  = 1'b1;
      id  = ID_JAL;
    end else if (pd_i.is_sys) begin
      fmt = FMT_I;
      unique case (pd_i.funct3)
        3'd0: begin
          if (pd_i.is_ecall) begin
            ok = 1'b1; id = ID_ECALL;
          end else if (pd_i.is_ebreak) begin
            ok = 1'b1; id = ID_EBREAK;
          end
        end
        3'd1: begin ok = 1'b1; id = ID_CSRRW;  end
        3'd2: begin ok = 1'b1; id = ID_CSRRS;  end
        3'd3: begin ok = 1'b1; id = ID_CSRRC;  end
        3'd5: begin ok = 1'b1; id = ID_CSRRWI; end
        3'd6: begin ok = 1'b1; id = ID_CSRRSI; end
        3'd7: begin ok = 1'b1; id = ID_CSRRCI; end
        default: ok = 1'b0;
      endcase
    end
  end

  // unrecognized words report id zero and no format
  assign cls_o.ok  = ok;
  assign cls_o.id  = ok ? id : ID_LB;
  assign cls_o.fmt = ok ? fmt : FMT_NONE;

endmodule

>>> rtl/rvid_imm_gen.sv
// immediate and csr address generation from the word and its format
module rvid_imm_gen import rvid_pkg::*; (
  input  logic [31:0] word_i,
  input  fmt_e        fmt_i,
  input  logic        is_sys_i,
  output logic [31:0] imm_o,
  output logic [11:0] csr_o
);

  // format-specific immediate assembly
  always_comb begin
    unique case (fmt_i)
      FMT_I: imm_o = is_sys_i ? {27'd0, word_i[19:15]}
                              : {{20{word_i[31]}}, word_i[31:20]};
      FMT_S: imm_o = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
      FMT_B: imm_o = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25],
                      word_i[11:8], 1'b0};
      FMT_U: imm_o = {word_i[31:12], 12'd0};
      FMT_J: imm_o = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20],
                      word_i[30:21], 1'b0};
      default: imm_o = 32'd0;
    endcase
  end

  // csr address only for recognized system words
  assign csr_o = (is_sys_i && (fmt_i == FMT_I)) ? word_i[31:20] : 12'd0;

endmodule

>>> rtl/rv32i_instruction_decoder_unit.sv
// top level: three-stage pipelined rv32i and zicsr instruction decoder
// path: an input word is registered by the predecode, then the classify, then the output
//   register before its result transaction is offered
// throughput: one instruction word per cycle while the output is not stalled; a stage
//   advances whenever it is empty or the stage after it advances (predecode, classify, immediate with output)
// reset: rst_ni clears all stage valid bits asynchronously; payload is not reset
module rv32i_instruction_decoder_unit import rvid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // instr_word[31:0]
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // instr_id[5:0], opcode[12:6], dest_reg[17:13], src1_reg[22:18],
  // src2_reg[27:23], funct3_field[30:28], funct7_field[37:31],
  // immediate[69:38], csr_addr[81:70], zero pad[87:82]
  output logic [TDATA_W-1:0]    m_axis_tdata,
  // recognized[0], format[3:1]
  output logic [TUSER_W-1:0]    m_axis_tuser
);

  // stage enables: a stage moves when it is empty or its successor moves
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: opcode class predecode
  predec_t     pd_d, pd_q;
  logic [31:0] word1_q;
  logic [6:0]  opc_in;

  assign opc_in = s_axis_tdata[6:0];

  always_comb begin
    pd_d.is_load   = (opc_in == OPC_LOAD);
    pd_d.is_fence  = (opc_in == OPC_MISC_MEM);
    pd_d.is_opimm  = (opc_in == OPC_OP_IMM);
    pd_d.is_auipc  = (opc_in == OPC_AUIPC);
    pd_d.is_store  = (opc_in == OPC_STORE);
    pd_d.is_op     = (opc_in == OPC_OP);
    pd_d.is_lui    = (opc_in == OPC_LUI);
    pd_d.is_branch = (opc_in == OPC_BRANCH);
    pd_d.is_jalr   = (opc_in == OPC_JALR);
    pd_d.is_jal    = (opc_in == OPC_JAL);
    pd_d.is_sys    = (opc_in == OPC_SYSTEM);
    pd_d.funct3    = s_axis_tdata[14:12];
    pd_d.f7_nz     = |s_axis_tdata[31:25];
    pd_d.is_ecall  = (s_axis_tdata == WORD_ECALL);
    pd_d.is_ebreak = (s_axis_tdata == WORD_EBREAK);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pd_q    <= pd_d;
      word1_q <= s_axis_tdata;
    end
  end

  // stage 2: operation id and format
  class_t      cls_d, cls_q;
  logic [31:0] word2_q;
  logic        sys2_q;

  rvid_id_decode u_id_decode (
    .pd_i  (pd_q),
    .cls_o (cls_d)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cls_q   <= cls_d;
      word2_q <= word1_q;
      sys2_q  <= pd_q.is_sys;
    end
  end

  // stage 3: immediate, csr address and output register
  logic [31:0]        imm;
  logic [11:0]        csr;
  logic [TDATA_W-1:0] tdata_d, tdata_q;
  logic [TUSER_W-1:0] tuser_d, tuser_q;

  rvid_imm_gen u_imm_gen (
    .word_i   (word2_q),
    .fmt_i    (cls_q.fmt),
    .is_sys_i (sys2_q),
    .imm_o    (imm),
    .csr_o    (csr)
  );

  assign tdata_d = {6'd0, csr, imm, word2_q[31:25], word2_q[14:12], word2_q[24:20],
                    word2_q[19:15], word2_q[11:7], word2_q[6:0], cls_q.id};
  assign tuser_d = {cls_q.fmt, cls_q.ok};

  always_ff @(posedge clk_i) begin
    if (en3) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

>>> rtl/rvid_checker.sv
// port-level checker for the rv32i decoder, bound to the top level
`include "assert_macros.svh"

module rvid_checker import rvid_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [TDATA_W-1:0]    m_axis_tdata,
  input logic [TUSER_W-1:0]    m_axis_tuser
);

  logic                       out_stall;
  logic [TDATA_W+TUSER_W-1:0] out_bus;
  logic                       unrec_ok;
  logic                       rfmt_ok;
  logic                       csr_ok;

  // result stream views
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_bus   = {m_axis_tuser, m_axis_tdata};
  assign unrec_ok  = !m_axis_tvalid || m_axis_tuser[0] ||
                     ((m_axis_tuser[3:1] == FMT_NONE) && (m_axis_tdata[5:0] == ID_LB) &&
                      (m_axis_tdata[81:38] == 44'd0));
  assign rfmt_ok   = !(m_axis_tvalid && m_axis_tuser[0] && (m_axis_tuser[3:1] == FMT_R)) ||
                     (m_axis_tdata[12:6] == OPC_OP);
  assign csr_ok    = !(m_axis_tvalid && (m_axis_tdata[81:70] != 12'd0)) ||
                     (m_axis_tdata[12:6] == OPC_SYSTEM);

  property p_stall_hold;
    out_stall |=> m_axis_tvalid && $stable(out_bus);
  endproperty

  // no output transaction is offered in the cycle after reset is seen
  `ASSERT_RST(a_rst_no_valid, clk_i, !rst_ni |=> !m_axis_tvalid, "valid after reset")

  // a stalled result keeps its payload
  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni, p_stall_hold, "stalled result changed")

  // an unrecognized word has no id, format, immediate or csr address
  `ASSERT_CLK(a_unrec_clean, clk_i, rst_ni, unrec_ok, "unrecognized result not cleared")

  // register format only comes from the op opcode
  `ASSERT_CLK(a_rfmt_opcode, clk_i, rst_ni, rfmt_ok, "r format with wrong opcode")

  // a csr address only appears on system words
  `ASSERT_CLK(a_csr_system, clk_i, rst_ni, csr_ok, "csr address on non-system word")

endmodule

bind rv32i_instruction_decoder_unit rvid_checker u_rvid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
